// File: sv/assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: sv/src_pkg.sv
package src_pkg;

  localparam int unsigned HEADER_BYTES = 32;
  localparam int unsigned HDR_IDX_W    = 5;
  localparam int unsigned COUNT_W      = 16;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
  localparam logic [HDR_IDX_W-1:0] HDR_CRC_SPAN = 5'd28;
  localparam logic [HDR_IDX_W-1:0] HDR_LAST     = 5'd31;

  localparam logic [1:0] VERDICT_COMPLETE = 2'd0;
  localparam logic [1:0] VERDICT_HDR_BAD  = 2'd1;
  localparam logic [1:0] VERDICT_CRC_BAD  = 2'd2;

  localparam logic [1:0] CFG_MAGIC     = 2'd0;
  localparam logic [1:0] CFG_NAMESPACE = 2'd1;
  localparam logic [1:0] CFG_SLOT_SIZE = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [7:0]  namespace_id;
    logic [16:0] slot_size;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  verdict;
    logic [15:0] major_version;
    logic [15:0] minor_version;
    logic [31:0] generation;
    logic [15:0] payload_length;
    logic [31:0] stored_crc;
  } res_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// File: sv/src_core.sv
module src_core #(
  parameter int unsigned MAX_SLOT_BYTES = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [7:0]       data_byte,
  input  logic             start_slot,
  input  src_pkg::cfg_t    cfg,
  output src_pkg::res_t    res
);
  import src_pkg::*;

  localparam logic [31:0] MaxSlot = 32'(MAX_SLOT_BYTES);

  phase_t               phase, phase_next, cur;
  logic [COUNT_W-1:0]   byte_count, byte_count_next, cnt, cnt_inc;
  logic [31:0]          header_crc, header_crc_next, hcrc_in, hcrc_new;
  logic [31:0]          body_crc, body_crc_next, bcrc_new;
  logic                 header_fault, header_fault_next, fault_in, fault_b, fault_now;
  logic [7:0]           header_bytes [HEADER_BYTES];
  logic [HDR_IDX_W-1:0] idx;

  logic [31:0] hdr_crc_word, gen_word, len_word, pcrc_word;
  logic [15:0] major_word, minor_word, len_sat;
  logic [16:0] eff, cap17;
  logic [15:0] cap;
  logic        hdr_last, crc_bad, early_bad, range_bad, len_zero, pay_last;

  assign cur      = start_slot ? PH_HEADER : phase;
  assign cnt      = start_slot ? '0 : byte_count;
  assign hcrc_in  = start_slot ? CRC_ONES : header_crc;
  assign fault_in = start_slot ? 1'b0 : header_fault;
  assign idx      = cnt[HDR_IDX_W-1:0];
  assign cnt_inc  = cnt + 1'b1;

  always_comb begin
    fault_b = 1'b0;
    if (idx < 5'd4) begin
      fault_b = data_byte != cfg.magic_word[{idx[1:0], 3'b000} +: 8];
    end else if (idx == 5'd4) begin
      fault_b = data_byte != cfg.namespace_id;
    end else if (idx == 5'd5 || idx == 5'd10 || idx == 5'd11 ||
                 (idx >= 5'd24 && idx < HDR_CRC_SPAN)) begin
      fault_b = data_byte != 8'd0;
    end
  end

  assign fault_now = fault_in | fault_b;
  assign hcrc_new  = (idx < HDR_CRC_SPAN) ? crc_byte(hcrc_in, data_byte) : hcrc_in;
  assign bcrc_new  = crc_byte(body_crc, data_byte);
  assign hdr_last  = idx == HDR_LAST;

  assign hdr_crc_word = {data_byte, header_bytes[30], header_bytes[29], header_bytes[28]};
  assign major_word   = {header_bytes[7], header_bytes[6]};
  assign minor_word   = {header_bytes[9], header_bytes[8]};
  assign gen_word     = {header_bytes[15], header_bytes[14], header_bytes[13], header_bytes[12]};
  assign len_word     = {header_bytes[19], header_bytes[18], header_bytes[17], header_bytes[16]};
  assign pcrc_word    = {header_bytes[23], header_bytes[22], header_bytes[21], header_bytes[20]};
  assign len_sat      = (len_word > 32'h0000FFFF) ? 16'hFFFF : len_word[15:0];

  assign eff   = ({15'd0, cfg.slot_size} > MaxSlot) ? MaxSlot[16:0] : cfg.slot_size;
  assign cap17 = (eff > 17'(HEADER_BYTES)) ? eff - 17'(HEADER_BYTES) : 17'd0;
  assign cap   = (cap17 > 17'h0FFFF) ? 16'hFFFF : cap17[15:0];

  assign crc_bad   = (hcrc_new ^ CRC_ONES) != hdr_crc_word;
  assign early_bad = fault_now | crc_bad;
  assign range_bad = (gen_word == 32'd0) || (len_word > {16'd0, cap});
  assign len_zero  = len_word == 32'd0;
  assign pay_last  = {16'd0, cnt_inc} >= len_word;

  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    header_crc_next   = header_crc;
    body_crc_next     = body_crc;
    header_fault_next = header_fault;
    if (fire) begin
      case (cur)
        PH_HEADER: begin
          header_fault_next = fault_now;
          header_crc_next   = hcrc_new;
          byte_count_next   = cnt_inc;
          phase_next        = PH_HEADER;
          if (hdr_last) begin
            if (early_bad || range_bad) begin
              header_fault_next = 1'b1;
              phase_next        = PH_DONE;
            end else begin
              body_crc_next   = CRC_ONES;
              byte_count_next = '0;
              phase_next      = len_zero ? PH_DONE : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          body_crc_next   = bcrc_new;
          byte_count_next = cnt_inc;
          if (pay_last) begin
            phase_next = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res                = '0;
    res.major_version  = major_word;
    res.minor_version  = minor_word;
    res.generation     = gen_word;
    res.payload_length = len_sat;
    res.stored_crc     = pcrc_word;
    case (cur)
      PH_HEADER: begin
        if (early_bad) begin
          res.verdict        = VERDICT_HDR_BAD;
          res.major_version  = '0;
          res.minor_version  = '0;
          res.generation     = '0;
          res.payload_length = '0;
          res.stored_crc     = '0;
        end else if (range_bad) begin
          res.verdict = VERDICT_HDR_BAD;
        end else begin
          res.verdict = (pcrc_word == 32'd0) ? VERDICT_COMPLETE : VERDICT_CRC_BAD;
        end
        res.valid = hdr_last && (early_bad || range_bad || len_zero);
      end
      PH_PAYLOAD: begin
        res.verdict = ((bcrc_new ^ CRC_ONES) == pcrc_word) ? VERDICT_COMPLETE
                                                           : VERDICT_CRC_BAD;
        res.valid   = pay_last;
      end
      default: begin
        res.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      byte_count   <= '0;
      header_crc   <= CRC_ONES;
      body_crc     <= CRC_ONES;
      header_fault <= 1'b0;
    end else begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      header_crc   <= header_crc_next;
      body_crc     <= body_crc_next;
      header_fault <= header_fault_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && cur == PH_HEADER) begin
      header_bytes[idx] <= data_byte;
    end
  end

endmodule

// File: sv/slot_record_checker.sv
// Slot record checker: validates one stored slot image streamed one byte per request.
// Input channel: in_valid/in_ready carry data_byte and start_slot; start_slot marks
// header byte 0 of a slot and restarts checking from any point.
// Output channel: out_valid/out_ready carry one verdict per slot with the header
// fields (versions, generation, payload length and stored payload CRC).
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index (0 magic word,
// 1 namespace id, 2 slot size); write only while no slot is in flight.
// Throughput: one byte per cycle, set by the byte-wide CRC step in the core, except
// while a byte is held back by a pending verdict. The deciding byte is held in the
// input register, and its verdict is loaded into the result register and raises
// out_valid when that byte fires into the core.
// Reset clears the channel valids, the checking state and the configuration to
// magic 0, namespace 1, slot size 4096; bytes before the first start are dropped.
// When the receiver stalls with a verdict pending, the block keeps accepting bytes
// that produce no verdict; a byte that would produce one waits in the input
// register and in_ready drops until the pending verdict is taken.
`include "assert_macros.svh"

module slot_record_checker #(
  parameter int unsigned MAX_SLOT_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        start_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  verdict,
  output logic [15:0] major_version,
  output logic [15:0] minor_version,
  output logic [31:0] generation,
  output logic [15:0] payload_length,
  output logic [31:0] stored_crc,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import src_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic       s1_valid, s1_start, s1_fire, s1_blocked;
  logic [7:0] s1_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_word   <= 32'd0;
      cfg.namespace_id <= 8'd1;
      cfg.slot_size    <= 17'd4096;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MAGIC:     cfg.magic_word   <= cfg_wdata;
        CFG_NAMESPACE: cfg.namespace_id <= cfg_wdata[7:0];
        CFG_SLOT_SIZE: cfg.slot_size    <= cfg_wdata[16:0];
        default: begin
        end
      endcase
    end
  end

  src_core #(
    .MAX_SLOT_BYTES(MAX_SLOT_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (s1_fire),
    .data_byte  (s1_byte),
    .start_slot (s1_start),
    .cfg        (cfg),
    .res        (res)
  );

  // hold a request that would produce a verdict while the previous one waits
  assign s1_blocked = s1_valid && res.valid && out_valid && !out_ready;
  assign s1_fire    = s1_valid && !s1_blocked;
  assign in_ready   = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte  <= data_byte;
      s1_start <= start_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res.valid) begin
      verdict        <= res.verdict;
      major_version  <= res.major_version;
      minor_version  <= res.minor_version;
      generation     <= res.generation;
      payload_length <= res.payload_length;
      stored_crc     <= res.stored_crc;
    end
  end

  `ASSERT_IMPLIES(a_verdict_code, clk, rst, out_valid,
    verdict == VERDICT_COMPLETE || verdict == VERDICT_HDR_BAD || verdict == VERDICT_CRC_BAD)
  `ASSERT_IMPLIES(a_gen_nonzero, clk, rst, out_valid && verdict != VERDICT_HDR_BAD,
    generation != 32'd0)
  `ASSERT_IMPLIES(a_stall_cause, clk, rst, !in_ready, s1_valid && out_valid && !out_ready)
  `ASSERT_NEXT(a_result_loaded, clk, rst, s1_fire && res.valid, out_valid)

endmodule
